>>> design/rap_pkg.sv
// ----------------------------------------------------------------------------
// rap_pkg
// Shared types, constants and helper functions for the residual apply
// plane store: plane geometry, bank layout, command codes, sample formats.
// ----------------------------------------------------------------------------
package rap_pkg;

  localparam int MaxWidth   = 64;
  localparam int MaxHeight  = 64;
  localparam int ClearBlock = 32;

  localparam int NumBanks  = 4;
  localparam int BankDepth = MaxWidth * MaxHeight / NumBanks;
  localparam int BankAw    = $clog2(BankDepth);

  // column and row positions with room for overhang past the store edge
  localparam int ColW = 7;
  localparam int RowW = 7;
  localparam int GrpW = ColW - 2;

  localparam int SampleW = 16;
  localparam int PaddrW  = 4;
  localparam int PdataW  = 32;

  typedef enum logic [3:0] {
    OP_WRITE = 4'd0,
    OP_READ  = 4'd1,
    OP_ADD2  = 4'd2,
    OP_ADD4  = 4'd3,
    OP_SET2  = 4'd4,
    OP_SET4  = 4'd5,
    OP_ZERO2 = 4'd6,
    OP_ZERO4 = 4'd7,
    OP_CLEAR = 4'd8
  } op_e;

  typedef enum logic [2:0] {
    FMT_U8  = 3'd0,
    FMT_U10 = 3'd1,
    FMT_U12 = 3'd2,
    FMT_U14 = 3'd3,
    FMT_S16 = 3'd4
  } fmt_e;

  typedef enum logic [1:0] {
    REG_FORMAT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_e;

  typedef struct packed {
    logic [2:0] fmt;
    logic [6:0] width;
    logic [6:0] height;
  } cfg_t;

  localparam logic [6:0] WidthReset  = 7'd64;
  localparam logic [6:0] HeightReset = 7'd64;
  localparam logic [15:0] UnsignedBias = 16'd16384;

  function automatic logic [2:0] fmt_shift(input logic [1:0] f);
    logic [2:0] s;
    case (f)
      2'd0:    s = 3'd7;
      2'd1:    s = 3'd5;
      2'd2:    s = 3'd3;
      default: s = 3'd1;
    endcase
    return s;
  endfunction

  function automatic logic [13:0] fmt_offset(input logic [1:0] f);
    logic [13:0] o;
    case (f)
      2'd0:    o = 14'h80;
      2'd1:    o = 14'd512;
      2'd2:    o = 14'd2048;
      default: o = 14'd8192;
    endcase
    return o;
  endfunction

  function automatic logic [13:0] fmt_max(input logic [1:0] f);
    logic [13:0] m;
    case (f)
      2'd0:    m = 14'd255;
      2'd1:    m = 14'd1023;
      2'd2:    m = 14'd4095;
      default: m = 14'd16383;
    endcase
    return m;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

>>> design/residual_apply_plane_store_core.sv
// ----------------------------------------------------------------------------
// residual_apply_plane_store_core
// 64x64 plane of 16-bit samples with per-row residual apply commands.
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o) takes one command word per row:
//   operation, origin, row within the unit and four residuals. every word
//   gives one result word on the output channel (out_valid_o / out_ready_i):
//   the four samples of the addressed row after the command.
//   the plane sits in four 1024-entry banks, one per column modulo four, so
//   a row of four columns is one read and one write-back of all banks.
//   a row command passes a bank read, then modify and write back; the
//   result register is loaded with the write-back, and the next word is
//   taken once the write-back is done.
//   clear walks the clipped block one four-column group per cycle, up to
//   32 rows of 9 groups, during which input is held off.
//   the result register keeps the finished word while the receiver stalls;
//   write-back of the next word waits until that register is free.
//   reset runs a clearing pass over all 1024 entries of each bank; no word is
//   accepted meanwhile, register writes are taken as usual.
//   registers: format at 0x0, plane width at 0x4, plane height at 0x8.
// ----------------------------------------------------------------------------
module residual_apply_plane_store_core import rap_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // apb
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [PaddrW-1:0]         paddr,
  input  logic [PdataW-1:0]         pwdata,
  output logic [PdataW-1:0]         prdata,
  output logic                      pready,
  // input words
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [3:0]                operation_i,
  input  logic [5:0]                pos_x_i,
  input  logic [5:0]                pos_y_i,
  input  logic [1:0]                unit_row_i,
  input  logic signed [SampleW-1:0] res_a_i,
  input  logic signed [SampleW-1:0] res_b_i,
  input  logic signed [SampleW-1:0] res_c_i,
  input  logic signed [SampleW-1:0] res_d_i,
  // output words
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] out_a_o,
  output logic signed [SampleW-1:0] out_b_o,
  output logic signed [SampleW-1:0] out_c_o,
  output logic signed [SampleW-1:0] out_d_o
);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_CLEAR
  } state_e;

  cfg_t cfg;

  rap_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e state_q, state_d;
  logic [BankAw-1:0] init_cnt_q, init_cnt_d;
  logic out_valid_q, out_valid_d;
  logic signed [SampleW-1:0] out_q [NumBanks];
  logic signed [SampleW-1:0] out_d [NumBanks];

  // clear walk
  logic [GrpW-1:0] grp_q, grp_d;
  logic [GrpW-1:0] grp_end_q, grp_end_d;
  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] clr_xhi_q, clr_xhi_d;
  logic [RowW-1:0] clr_yhi_q, clr_yhi_d;

  // captured word
  logic [3:0]                op_q;
  logic [5:0]                x_q;
  logic [5:0]                y_q;
  logic [1:0]                ur_q;
  logic [RowW-1:0]           r_q;
  logic signed [SampleW-1:0] res_q [NumBanks];

  logic accept;
  logic exec_go;

  // bank ports
  logic                      rd_en;
  logic [RowW-1:0]           rd_row;
  logic [1:0]                rd_j    [NumBanks];
  logic [ColW-1:0]           rd_col  [NumBanks];
  logic [BankAw-1:0]         rd_addr [NumBanks];
  logic [SampleW-1:0]        rdata   [NumBanks];
  logic                      wr_en   [NumBanks];
  logic [BankAw-1:0]         wr_addr [NumBanks];
  logic [SampleW-1:0]        wr_data [NumBanks];

  // per-bank view of the captured word
  logic [1:0]                it_j    [NumBanks];
  logic [ColW-1:0]           it_col  [NumBanks];
  logic                      it_in   [NumBanks];
  logic                      it_we   [NumBanks];
  logic signed [SampleW-1:0] it_nv   [NumBanks];
  logic signed [SampleW-1:0] it_sum  [NumBanks];
  logic signed [SampleW-1:0] view    [NumBanks];
  logic [ColW-1:0]           clr_c   [NumBanks];
  logic                      clr_we  [NumBanks];

  logic [ColW-1:0] cols_raw, cols;
  logic [RowW-1:0] rows_raw, rows;
  logic [ColW-1:0] last_col;
  logic [RowW-1:0] row_nxt;
  logic            pair_ok;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign exec_go    = (state_q == S_EXEC) & (~out_valid_q | out_ready_i);
  assign rd_en      = accept;
  assign rd_row     = {1'b0, pos_y_i} + {5'b0, unit_row_i};

  always_comb begin
    for (int k = 0; k < NumBanks; k++) begin
      rd_j[k]    = 2'(k) - pos_x_i[1:0];
      rd_col[k]  = {1'b0, pos_x_i} + {5'b0, rd_j[k]};
      rd_addr[k] = {rd_row[5:0], rd_col[k][5:2]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      x_q      <= pos_x_i;
      y_q      <= pos_y_i;
      ur_q     <= unit_row_i;
      r_q      <= rd_row;
      res_q[0] <= res_a_i;
      res_q[1] <= res_b_i;
      res_q[2] <= res_c_i;
      res_q[3] <= res_d_i;
    end
  end

  // clipped clear size
  always_comb begin
    cols_raw = (cfg.width > {1'b0, x_q}) ? cfg.width - {1'b0, x_q} : '0;
    cols     = (cols_raw > 7'(ClearBlock)) ? 7'(ClearBlock) : cols_raw;
    rows_raw = (cfg.height > {1'b0, y_q}) ? cfg.height - {1'b0, y_q} : '0;
    rows     = (rows_raw > 7'(ClearBlock)) ? 7'(ClearBlock) : rows_raw;
    last_col = {1'b0, x_q} + cols - 7'd1;
    pair_ok  = (ur_q < 2'd2);
  end

  for (genvar g = 0; g < NumBanks; g++) begin : g_bank
    rap_sample_ram u_ram (
      .clk_i   (clk_i),
      .we_i    (wr_en[g]),
      .waddr_i (wr_addr[g]),
      .wdata_i (wr_data[g]),
      .re_i    (rd_en),
      .raddr_i (rd_addr[g]),
      .rdata_o (rdata[g])
    );

    rap_sample_alu u_alu (
      .fmt_i    (cfg.fmt),
      .sample_i (signed'(rdata[g])),
      .res_i    (res_q[it_j[g]]),
      .sum_o    (it_sum[g])
    );
  end

  // modify step and result view per bank
  always_comb begin
    for (int k = 0; k < NumBanks; k++) begin
      it_j[k]   = 2'(k) - x_q[1:0];
      it_col[k] = {1'b0, x_q} + {5'b0, it_j[k]};
      it_in[k]  = ~it_col[k][6] & ~r_q[6];
      it_we[k]  = 1'b0;
      it_nv[k]  = '0;
      unique case (op_q)
        OP_WRITE, OP_SET4: begin
          it_we[k] = 1'b1;
          it_nv[k] = res_q[it_j[k]];
        end
        OP_SET2: begin
          it_we[k] = pair_ok & ~it_j[k][1];
          it_nv[k] = res_q[it_j[k]];
        end
        OP_ADD4: begin
          it_we[k] = 1'b1;
          it_nv[k] = it_sum[k];
        end
        OP_ADD2: begin
          it_we[k] = pair_ok & ~it_j[k][1];
          it_nv[k] = it_sum[k];
        end
        OP_ZERO4: it_we[k] = 1'b1;
        OP_ZERO2: it_we[k] = pair_ok & ~it_j[k][1];
        default:  it_we[k] = 1'b0;
      endcase
      it_we[k] = it_we[k] & it_in[k];

      if (!it_in[k]) begin
        view[k] = '0;
      end else if (it_we[k]) begin
        view[k] = it_nv[k];
      end else if ((op_q == OP_CLEAR) && ({5'b0, it_j[k]} < cols)
                   && ({5'b0, ur_q} < rows)) begin
        view[k] = '0;
      end else begin
        view[k] = signed'(rdata[k]);
      end

      clr_c[k]  = {grp_q, 2'(k)};
      clr_we[k] = (clr_c[k] >= {1'b0, x_q}) & (clr_c[k] < clr_xhi_q)
                & ~clr_c[k][6] & ~row_q[6];
    end
  end

  // bank write port selection
  always_comb begin
    for (int k = 0; k < NumBanks; k++) begin
      unique case (state_q)
        S_INIT: begin
          wr_en[k]   = 1'b1;
          wr_addr[k] = init_cnt_q;
          wr_data[k] = '0;
        end
        S_EXEC: begin
          wr_en[k]   = exec_go & it_we[k];
          wr_addr[k] = {r_q[5:0], it_col[k][5:2]};
          wr_data[k] = it_nv[k];
        end
        S_CLEAR: begin
          wr_en[k]   = clr_we[k];
          wr_addr[k] = {row_q[5:0], grp_q[3:0]};
          wr_data[k] = '0;
        end
        default: begin
          wr_en[k]   = 1'b0;
          wr_addr[k] = init_cnt_q;
          wr_data[k] = '0;
        end
      endcase
    end
  end

  assign row_nxt = row_q + 7'd1;

  always_comb begin
    state_d     = state_q;
    init_cnt_d  = init_cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    grp_d       = grp_q;
    grp_end_d   = grp_end_q;
    row_d       = row_q;
    clr_xhi_d   = clr_xhi_q;
    clr_yhi_d   = clr_yhi_q;
    unique case (state_q)
      S_INIT: begin
        init_cnt_d = init_cnt_q + BankAw'(1);
        if (&init_cnt_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          out_valid_d = 1'b1;
          for (int j = 0; j < NumBanks; j++) begin
            out_d[j] = view[x_q[1:0] + 2'(j)];
          end
          state_d   = S_IDLE;
          grp_d     = {1'b0, x_q[5:2]};
          grp_end_d = last_col[6:2];
          row_d     = {1'b0, y_q};
          clr_xhi_d = {1'b0, x_q} + cols;
          clr_yhi_d = {1'b0, y_q} + rows;
          if ((op_q == OP_CLEAR) && (cols != '0) && (rows != '0)) begin
            state_d = S_CLEAR;
          end
        end
      end
      S_CLEAR: begin
        if (grp_q == grp_end_q) begin
          grp_d = {1'b0, x_q[5:2]};
          row_d = row_nxt;
          if (row_nxt == clr_yhi_q) begin
            state_d = S_IDLE;
          end
        end else begin
          grp_d = grp_q + GrpW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_cnt_q  <= '0;
      out_valid_q <= 1'b0;
      for (int j = 0; j < NumBanks; j++) begin
        out_q[j] <= '0;
      end
      grp_q       <= '0;
      grp_end_q   <= '0;
      row_q       <= '0;
      clr_xhi_q   <= '0;
      clr_yhi_q   <= '0;
    end else begin
      state_q     <= state_d;
      init_cnt_q  <= init_cnt_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      grp_q       <= grp_d;
      grp_end_q   <= grp_end_d;
      row_q       <= row_d;
      clr_xhi_q   <= clr_xhi_d;
      clr_yhi_q   <= clr_yhi_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_a_o     = out_q[0];
  assign out_b_o     = out_q[1];
  assign out_c_o     = out_q[2];
  assign out_d_o     = out_q[3];

endmodule

>>> design/rap_sample_ram.sv
// ----------------------------------------------------------------------------
// rap_sample_ram
// One sample bank: synchronous memory with a write port and a read port,
// read data registered.
// ----------------------------------------------------------------------------
module rap_sample_ram import rap_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [BankAw-1:0]  waddr_i,
  input  logic [SampleW-1:0] wdata_i,
  input  logic               re_i,
  input  logic [BankAw-1:0]  raddr_i,
  output logic [SampleW-1:0] rdata_o
);

  logic [SampleW-1:0] mem [BankDepth];
  logic [SampleW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/rap_sample_alu.sv
// ----------------------------------------------------------------------------
// rap_sample_alu
// Residual add for one sample: saturating add for the signed format, and
// for unsigned formats the shift up, bias, saturating add, rounding shift
// down, offset and clamp.
// ----------------------------------------------------------------------------
module rap_sample_alu import rap_pkg::*; (
  input  logic [2:0]                fmt_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic signed [SampleW-1:0] res_i,
  output logic signed [SampleW-1:0] sum_o
);

  logic [2:0]          sh;
  logic [15:0]         up;
  logic signed [15:0]  biased;
  logic signed [15:0]  added;
  logic [15:0]         ofs_bin;
  logic [16:0]         rounded;
  logic [16:0]         down;
  logic [16:0]         bias_down;
  logic signed [17:0]  scaled;
  logic [13:0]         maxv;

  always_comb begin
    sh        = fmt_shift(fmt_i[1:0]);
    maxv      = fmt_max(fmt_i[1:0]);
    up        = 16'(sample_i << sh);
    biased    = signed'(up - UnsignedBias);
    added     = sat16(17'(biased) + 17'(res_i));
    // offset binary is the same as adding 32768
    ofs_bin   = {~added[15], added[14:0]};
    rounded   = {1'b0, ofs_bin} + (17'd1 << (sh - 3'd1));
    down      = rounded >> sh;
    bias_down = 17'd32768 >> sh;
    scaled    = signed'({1'b0, down}) - signed'({1'b0, bias_down})
              + signed'({4'b0, fmt_offset(fmt_i[1:0])});

    if (fmt_i > 3'(FMT_U14)) begin
      sum_o = sat16(17'(sample_i) + 17'(res_i));
    end else if (scaled < 18'sd0) begin
      sum_o = '0;
    end else if (scaled > signed'({4'b0, maxv})) begin
      sum_o = signed'({2'b0, maxv});
    end else begin
      sum_o = scaled[15:0];
    end
  end

endmodule

>>> design/rap_cfg_regs.sv
// ----------------------------------------------------------------------------
// rap_cfg_regs
// APB-style register file: sample format and active plane size.
// ----------------------------------------------------------------------------
module rap_cfg_regs import rap_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_FORMAT: cfg_d.fmt    = pwdata[2:0];
        REG_WIDTH:  cfg_d.width  = pwdata[6:0];
        REG_HEIGHT: cfg_d.height = pwdata[6:0];
        default:    cfg_d        = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FORMAT: prdata = {29'b0, cfg_q.fmt};
      REG_WIDTH:  prdata = {25'b0, cfg_q.width};
      REG_HEIGHT: prdata = {25'b0, cfg_q.height};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fmt    <= 3'(FMT_U8);
      cfg_q.width  <= WidthReset;
      cfg_q.height <= HeightReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
